@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the list controller and datapath.
// Depends on a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PLI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pli_pkg.sv @@
// Package for the positional list: payload structs, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   localparam int LIST_DEPTH_DEFAULT = 64;
   localparam int KIND_WIDTH = 3;
   localparam int POS_WIDTH = 7;
   localparam int VALUE_WIDTH = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH = 7;

   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_DELETE = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_SEARCH = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_READ = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] RSP_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] RSP_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] RSP_FULL = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] RSP_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]         kind;
      logic [POS_WIDTH-1:0]          position;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]       status;
      logic [POS_WIDTH-1:0]          found_position;
      logic signed [VALUE_WIDTH-1:0] read_value;
      logic [COUNT_WIDTH-1:0]        count;
   } rsp_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DECODE,
      CS_SHIFT_UP,
      CS_DRAIN_UP,
      CS_PLACE,
      CS_SHIFT_DOWN,
      CS_DRAIN_DOWN,
      CS_SCAN,
      CS_FETCH,
      CS_FETCH_WAIT,
      CS_FINISH
   } ctl_state_type;

   typedef enum logic [2:0] {
      ADDR_HOLD,
      ADDR_TOP,
      ADDR_POS,
      ADDR_POS_M1,
      ADDR_ZERO,
      ADDR_INC,
      ADDR_DEC
   } addr_op_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_RANGE,
      RES_FULL,
      RES_NOT_FOUND,
      RES_FOUND,
      RES_READ
   } res_op_type;

   typedef struct packed {
      logic        load_req;
      logic        rd_en;
      logic        wr_up;
      logic        wr_down;
      logic        wr_place;
      logic        count_clear;
      logic        count_inc;
      logic        count_dec;
      logic        rsp_load;
      addr_op_type addr_op;
      res_op_type  res_op;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0] kind;
      logic                  full;
      logic                  empty;
      logic                  ins_ok;
      logic                  append;
      logic                  pos_ok;
      logic                  pos_top;
      logic                  at_floor;
      logic                  at_ceil;
      logic                  scan_last;
      logic                  hit;
      logic                  pend;
      logic                  rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/positional_list_insert_delete_search.sv @@
// Top level of the positional list: controller plus datapath.
// Depends on pli_pkg, pli_ctrl and pli_datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    pli_pkg::req_type
//   rsp       out         rsp_valid/rsp_ready    pli_pkg::rsp_type
//
// One request at a time. Insert shifts the entries from position p up (none when
// appending), delete shifts them down (none for the last entry), search reads up to
// all n entries: the walk moves one entry per cycle through the single read port.
// The response register lets the next request start while a response waits.
// Synchronous active-high reset empties the list; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_insert_delete_search #(
   parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pli_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pli_pkg::rsp_type       rsp_data
);
   import pli_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pli_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

@@ rtl/core/pli_datapath.sv @@
// Datapath of the positional list: entry memory, walk address, count,
// result and response registers. Depends on pli_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pli_datapath #(
   parameter int LIST_DEPTH = pli_pkg::LIST_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pli_pkg::req_type      req_data,
   output pli_pkg::rsp_type           rsp_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire pli_pkg::dp_cmd_type   cmd,
   output pli_pkg::dp_status_type     status
);
   import pli_pkg::*;

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int XW = ((CW > POS_WIDTH) ? CW : POS_WIDTH) + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   logic [VALUE_WIDTH-1:0]  entries_mem [LIST_DEPTH];

   req_type                 req_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [AW-1:0]           rd_addr_ff;
   logic                    pend_ff;
   logic [VALUE_WIDTH-1:0]  rd_data_ff;
   logic [STATUS_WIDTH-1:0] res_status_ff, res_status_in;
   logic [POS_WIDTH-1:0]    res_found_ff, res_found_in;
   logic [VALUE_WIDTH-1:0]  res_read_ff, res_read_in;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [VALUE_WIDTH-1:0]  wr_data;
   logic [XW-1:0]           pos_x, count_x, pos_m1_x;
   logic [CW-1:0]           count_m1;
   logic [AW:0]             found_sum;

   assign pos_x     = XW'(req_ff.position);
   assign count_x   = XW'(count_ff);
   assign pos_m1_x  = pos_x - XW'(1);
   assign count_m1  = count_ff - CW'(1);
   assign found_sum = {1'b0, rd_addr_ff} + (AW + 1)'(1);

   always_comb begin
      status.kind      = req_ff.kind;
      status.full      = (count_ff == DEPTH_C);
      status.empty     = (count_ff == '0);
      status.ins_ok    = (pos_x != '0) && (pos_x <= count_x + XW'(1));
      status.append    = (pos_x == count_x + XW'(1));
      status.pos_ok    = (pos_x != '0) && (pos_x <= count_x);
      status.pos_top   = (pos_x == count_x);
      status.at_floor  = (addr_ff == pos_m1_x[AW-1:0]);
      status.at_ceil   = (addr_ff == count_m1[AW-1:0]);
      status.scan_last = pend_ff && (rd_addr_ff == count_m1[AW-1:0]);
      status.hit       = pend_ff && (rd_data_ff == req_ff.value);
      status.pend      = pend_ff;
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.addr_op)
         ADDR_TOP:    addr_in = count_m1[AW-1:0];
         ADDR_POS:    addr_in = pos_x[AW-1:0];
         ADDR_POS_M1: addr_in = pos_m1_x[AW-1:0];
         ADDR_ZERO:   addr_in = '0;
         ADDR_INC:    addr_in = addr_ff + AW'(1);
         ADDR_DEC:    addr_in = addr_ff - AW'(1);
         default:     addr_in = addr_ff;
      endcase
   end

   always_comb begin
      wr_en   = cmd.wr_up || cmd.wr_down || cmd.wr_place;
      wr_data = rd_data_ff;
      if (cmd.wr_place) begin
         wr_addr = pos_m1_x[AW-1:0];
         wr_data = req_ff.value;
      end else if (cmd.wr_up) begin
         wr_addr = rd_addr_ff + AW'(1);
      end else begin
         wr_addr = rd_addr_ff - AW'(1);
      end
   end

   always_comb begin
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_m1;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_read_in   = res_read_ff;
      if (cmd.load_req) begin
         res_status_in = RSP_OK;
         res_found_in  = '0;
         res_read_in   = '0;
      end else begin
         case (cmd.res_op)
            RES_RANGE:     res_status_in = RSP_RANGE;
            RES_FULL:      res_status_in = RSP_FULL;
            RES_NOT_FOUND: res_status_in = RSP_NOT_FOUND;
            RES_FOUND: begin
               res_status_in = RSP_OK;
               res_found_in  = POS_WIDTH'(found_sum);
            end
            RES_READ: begin
               res_status_in = RSP_OK;
               res_read_in   = rd_data_ff;
            end
            default: begin
               res_status_in = res_status_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entries_mem[addr_ff];
         rd_addr_ff <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_read_ff   <= res_read_in;
      if (cmd.rsp_load) begin
         rsp_ff.status         <= res_status_ff;
         rsp_ff.found_position <= res_found_ff;
         rsp_ff.read_value     <= res_read_ff;
         rsp_ff.count          <= COUNT_WIDTH'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= cmd.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `PLI_ASSERT(a_one_writer, $onehot0({cmd.wr_up, cmd.wr_down, cmd.wr_place}), "two write sources")
   `PLI_ASSERT(a_rsp_slot, cmd.rsp_load |-> !rsp_valid_ff || rsp_ready, "response overwritten")
   `PLI_ASSERT(a_count_bound, count_ff <= DEPTH_C, "count beyond depth")
   `PLI_ASSERT_NEXT(a_count_hold, !cmd.count_clear && !cmd.count_inc && !cmd.count_dec, $stable(count_ff), "count moved without command")

endmodule

`default_nettype wire

@@ rtl/core/pli_ctrl.sv @@
// Controller of the positional list: decodes each request and sequences
// the memory walks. Depends on pli_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pli_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire pli_pkg::dp_status_type status,
   output pli_pkg::dp_cmd_type         cmd
);
   import pli_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            case (status.kind)
               KIND_INSERT: begin
                  if (status.full || !status.ins_ok) begin
                     state_in = CS_FINISH;
                  end else if (status.append) begin
                     state_in = CS_PLACE;
                  end else begin
                     state_in = CS_SHIFT_UP;
                  end
               end
               KIND_DELETE: begin
                  if (!status.pos_ok || status.pos_top) begin
                     state_in = CS_FINISH;
                  end else begin
                     state_in = CS_SHIFT_DOWN;
                  end
               end
               KIND_SEARCH: state_in = status.empty ? CS_FINISH : CS_SCAN;
               KIND_READ:   state_in = status.pos_ok ? CS_FETCH : CS_FINISH;
               default:     state_in = CS_FINISH;
            endcase
         end
         CS_SHIFT_UP: begin
            if (status.at_floor) begin
               state_in = CS_DRAIN_UP;
            end
         end
         CS_DRAIN_UP:   state_in = CS_PLACE;
         CS_PLACE:      state_in = CS_FINISH;
         CS_SHIFT_DOWN: begin
            if (status.at_ceil) begin
               state_in = CS_DRAIN_DOWN;
            end
         end
         CS_DRAIN_DOWN: state_in = CS_FINISH;
         CS_SCAN: begin
            if (status.hit || status.scan_last) begin
               state_in = CS_FINISH;
            end
         end
         CS_FETCH:      state_in = CS_FETCH_WAIT;
         CS_FETCH_WAIT: state_in = CS_FINISH;
         CS_FINISH: begin
            if (status.rsp_free) begin
               state_in = CS_IDLE;
            end
         end
         default:       state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.addr_op = ADDR_HOLD;
      cmd.res_op  = RES_HOLD;
      case (state_ff)
         CS_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         CS_DECODE: begin
            case (status.kind)
               KIND_CLEAR: cmd.count_clear = 1'b1;
               KIND_INSERT: begin
                  if (status.full) begin
                     cmd.res_op = RES_FULL;
                  end else if (!status.ins_ok) begin
                     cmd.res_op = RES_RANGE;
                  end else if (!status.append) begin
                     cmd.addr_op = ADDR_TOP;
                  end
               end
               KIND_DELETE: begin
                  if (!status.pos_ok) begin
                     cmd.res_op = RES_RANGE;
                  end else if (status.pos_top) begin
                     cmd.count_dec = 1'b1;
                  end else begin
                     cmd.addr_op = ADDR_POS;
                  end
               end
               KIND_SEARCH: begin
                  if (status.empty) begin
                     cmd.res_op = RES_NOT_FOUND;
                  end else begin
                     cmd.addr_op = ADDR_ZERO;
                  end
               end
               KIND_READ: begin
                  if (status.pos_ok) begin
                     cmd.addr_op = ADDR_POS_M1;
                  end else begin
                     cmd.res_op = RES_RANGE;
                  end
               end
               default: cmd.res_op = RES_HOLD;
            endcase
         end
         CS_SHIFT_UP: begin
            cmd.rd_en   = 1'b1;
            cmd.addr_op = ADDR_DEC;
            cmd.wr_up   = status.pend;
         end
         CS_DRAIN_UP: cmd.wr_up = 1'b1;
         CS_PLACE: begin
            cmd.wr_place  = 1'b1;
            cmd.count_inc = 1'b1;
         end
         CS_SHIFT_DOWN: begin
            cmd.rd_en   = 1'b1;
            cmd.addr_op = ADDR_INC;
            cmd.wr_down = status.pend;
         end
         CS_DRAIN_DOWN: begin
            cmd.wr_down   = 1'b1;
            cmd.count_dec = 1'b1;
         end
         CS_SCAN: begin
            if (status.hit) begin
               cmd.res_op = RES_FOUND;
            end else if (status.scan_last) begin
               cmd.res_op = RES_NOT_FOUND;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.addr_op = ADDR_INC;
            end
         end
         CS_FETCH:      cmd.rd_en = 1'b1;
         CS_FETCH_WAIT: cmd.res_op = RES_READ;
         CS_FINISH:     cmd.rsp_load = status.rsp_free;
         default:       req_ready = 1'b0;
      endcase
   end

   `PLI_ASSERT_NEXT(a_accept_decode, req_valid && req_ready, state_ff == CS_DECODE, "accept without decode")
   `PLI_ASSERT_NEXT(a_finish_hold, state_ff == CS_FINISH && !status.rsp_free, state_ff == CS_FINISH, "left finish while response blocked")

endmodule

`default_nettype wire

@@ tb/positional_list_insert_delete_search_tb.sv @@
// Testbench for positional_list_insert_delete_search: random and directed list requests.
// A scoreboard class keeps its own copy of the list and checks each response in order.
// Depends on pli_pkg and the positional_list_insert_delete_search RTL.
`timescale 1ns / 1ps

import pli_pkg::*;

class list_scoreboard;
   localparam int DEPTH = LIST_DEPTH_DEFAULT;

   logic signed [VALUE_WIDTH-1:0] words [DEPTH];
   int                            held;
   rsp_type                       pending_rsp [$];
   int                            errors;

   function new();
      held = 0;
      errors = 0;
   endfunction

   function int pending();
      return pending_rsp.size();
   endfunction

   function void apply_request(input req_type r);
      rsp_type want;
      int      p;
      logic    hit;
      want = '0;
      p = int'(r.position);
      hit = 1'b0;
      case (r.kind)
         KIND_CLEAR: begin
            held = 0;
         end
         KIND_INSERT: begin
            if (held >= DEPTH) begin
               want.status = RSP_FULL;
            end else if (p < 1 || p > held + 1) begin
               want.status = RSP_RANGE;
            end else begin
               for (int i = held; i >= p; i--)
                  words[i] = words[i-1];
               words[p-1] = r.value;
               held++;
            end
         end
         KIND_DELETE: begin
            if (p < 1 || p > held) begin
               want.status = RSP_RANGE;
            end else begin
               for (int i = p - 1; i + 1 < held; i++)
                  words[i] = words[i+1];
               held--;
            end
         end
         KIND_SEARCH: begin
            want.status = RSP_NOT_FOUND;
            for (int i = 0; i < held && !hit; i++) begin
               if (words[i] == r.value) begin
                  hit = 1'b1;
                  want.status = RSP_OK;
                  want.found_position = 7'(i + 1);
               end
            end
         end
         KIND_READ: begin
            if (p < 1 || p > held)
               want.status = RSP_RANGE;
            else
               want.read_value = words[p-1];
         end
         default: begin
         end
      endcase
      want.count = 7'(held);
      pending_rsp.push_back(want);
   endfunction

   function void check_response(input rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.found_position !== want.found_position) begin
         $error("found_position: expected %0d, got %0d", want.found_position,
                got.found_position);
         errors++;
      end
      if (got.read_value !== want.read_value) begin
         $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
         errors++;
      end
      if (got.count !== want.count) begin
         $error("count: expected %0d, got %0d", want.count, got.count);
         errors++;
      end
   endfunction
endclass

module positional_list_insert_delete_search_tb;

   localparam int DEPTH = LIST_DEPTH_DEFAULT;
   localparam int RANDOM_REQUESTS = 1750;
   localparam int LONG_HOLD = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int TAIL_CYCLES = 100;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic    quiet = 1'b0;
   logic    hold_request = 1'b0;

   list_scoreboard sb = new();

   positional_list_insert_delete_search u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         return $urandom_range(1, 3);
      else if (sel < 93)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 50);
   endfunction

   function automatic int sender_gap();
      if (quiet || $urandom_range(0, 99) < 60)
         return 0;
      return pick_gap();
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         return $urandom_range(0, 15) - 8;
      else if (sel == 4)
         return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      else
         return $urandom;
   endfunction

   function automatic req_type make_req(input logic [KIND_WIDTH-1:0] kind, input int pos,
                                        input logic signed [VALUE_WIDTH-1:0] value);
      req_type r;
      r.kind = kind;
      r.position = 7'(pos);
      r.value = value;
      return r;
   endfunction

   function automatic req_type next_request(input int target);
      req_type     r;
      int unsigned sel;
      int unsigned end_sel;
      int          n;
      n = sb.held;
      r.position = '0;
      r.value = pick_value();
      sel = $urandom_range(0, 99);
      if (sel < 1 && target <= 16)
         r.kind = KIND_CLEAR;
      else if (sel < 3 && sel >= 1)
         r.kind = 3'($urandom_range(5, 7));
      else if (sel < 18)
         r.kind = KIND_SEARCH;
      else if (sel < 33)
         r.kind = KIND_READ;
      else if (sel < 33 + (n < target ? 50 : 20))
         r.kind = KIND_INSERT;
      else
         r.kind = KIND_DELETE;

      sel = $urandom_range(0, 99);
      end_sel = $urandom_range(0, 9);
      if (sel < 6) begin
         r.position = 7'($urandom_range(0, 127));
      end else if (sel < 9) begin
         if (end_sel < 3)
            r.position = '0;
         else
            r.position = 7'(r.kind == KIND_INSERT ? n + 2 : n + 1);
      end else if (r.kind == KIND_INSERT) begin
         if (end_sel < 2)
            r.position = 7'd1;
         else if (end_sel < 4)
            r.position = 7'(n + 1);
         else
            r.position = 7'($urandom_range(1, n + 1));
      end else if (n == 0) begin
         r.position = 7'($urandom_range(0, 127));
      end else begin
         if (end_sel < 2)
            r.position = 7'd1;
         else if (end_sel < 4)
            r.position = 7'(n);
         else
            r.position = 7'($urandom_range(1, n));
      end

      if (r.kind == KIND_SEARCH && n > 0 && $urandom_range(0, 1))
         r.value = sb.words[$urandom_range(0, n - 1)];
      return r;
   endfunction

   // Enter and leave at a falling edge; valid is left high, and a later gap or wait_drained lowers it.
   task automatic send_request(input req_type r, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.apply_request(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            stall_left = pick_gap() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle = 0;
         else
            idle++;
      end
      $display("positional_list_insert_delete_search_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int target;
      target = DEPTH;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(make_req(KIND_READ, 1, 0), sender_gap());
      send_request(make_req(KIND_DELETE, 1, 0), sender_gap());
      send_request(make_req(KIND_SEARCH, 0, 0), sender_gap());
      send_request(make_req(KIND_INSERT, 0, 5), sender_gap());
      send_request(make_req(KIND_INSERT, 2, 5), sender_gap());
      send_request(make_req(KIND_INSERT, 1, VALUE_MAX), sender_gap());
      send_request(make_req(KIND_INSERT, 1, VALUE_MIN), sender_gap());
      send_request(make_req(KIND_INSERT, 3, -1), sender_gap());
      send_request(make_req(KIND_INSERT, 2, 0), sender_gap());
      send_request(make_req(KIND_INSERT, 2, VALUE_MAX), sender_gap());
      send_request(make_req(KIND_SEARCH, 0, VALUE_MAX), sender_gap());
      send_request(make_req(KIND_SEARCH, 127, 5), sender_gap());
      send_request(make_req(KIND_READ, 5, 0), sender_gap());
      send_request(make_req(KIND_READ, 6, 0), sender_gap());
      send_request(make_req(KIND_READ, 127, 0), sender_gap());
      send_request(make_req(KIND_DELETE, 1, 0), sender_gap());
      send_request(make_req(KIND_DELETE, 4, 0), sender_gap());
      send_request(make_req(KIND_DELETE, 0, 0), sender_gap());
      send_request(make_req(3'd5, 127, VALUE_MIN), sender_gap());
      send_request(make_req(3'd6, 64, -1), sender_gap());
      send_request(make_req(3'd7, 1, VALUE_MAX), sender_gap());
      send_request(make_req(KIND_CLEAR, 127, -1), sender_gap());
      send_request(make_req(KIND_READ, 1, 0), sender_gap());
      send_request(make_req(KIND_SEARCH, 0, 0), sender_gap());

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 150 == 0 && i > 0) begin
            case ($urandom_range(0, 4))
               0: target = 0;
               1: target = 6;
               2: target = 32;
               default: target = DEPTH;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
         end
         if (i == 500)
            hold_request = 1'b1;
         if (i == 1100)
            wait_drained();
         send_request(next_request(target), (i >= 500 && i < 520) ? 0 : sender_gap());
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("positional_list_insert_delete_search_tb OK");
      else
         $display("positional_list_insert_delete_search_tb NOT OK");
      $finish;
   end

endmodule
